// File: hdl/rgb_to_visual_pixel_packer_top_defines.svh
// Assertion helpers shared by the checker. Each expects clk and rst_n in scope.
`ifndef RGB_TO_VISUAL_PIXEL_PACKER_TOP_DEFINES_SVH
`define RGB_TO_VISUAL_PIXEL_PACKER_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define RTVPP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtvpp checker: property failed");

// Next-cycle implication, ignored while reset is asserted.
`define RTVPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtvpp checker: property failed");

`endif

// File: hdl/rtvpp_pkg.sv
package rtvpp_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
    localparam int PROD_W      = SAMPLE_BITS + 32;
    // Number of shifted partial terms in the reciprocal estimate.
    localparam int NUM_TERMS   = (PROD_W - 1) / SAMPLE_BITS;
    localparam int REM_W       = $clog2((NUM_TERMS + 1) * SAMPLE_MAX);
    localparam int CORR_W      = $clog2(NUM_TERMS + 1);

    localparam logic [2:0] CFG_RED_MASK   = 3'd0;
    localparam logic [2:0] CFG_GREEN_MASK = 3'd1;
    localparam logic [2:0] CFG_BLUE_MASK  = 3'd2;
    localparam logic [2:0] CFG_WIDE       = 3'd3;
    localparam logic [2:0] CFG_MSB_FIRST  = 3'd4;
    localparam logic [2:0] CFG_GRAY       = 3'd5;

    localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;

    localparam logic [2:0] COUNT_WIDE   = 3'd4;
    localparam logic [2:0] COUNT_NARROW = 3'd2;

    typedef struct packed {
        logic [31:0] level;
        logic [4:0]  sh;
    } chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  wide;
        logic  msb;
        logic  gray;
    } cfg_t;

    // Index of the lowest set bit; zero for an empty mask.
    function automatic logic [4:0] ctz32(input logic [31:0] m);
        logic [4:0] n;
        n = '0;
        for (int i = 31; i >= 0; i--) begin
            if (m[i])
            begin
                n = 5'(i);
            end
        end
        return n;
    endfunction

    function automatic chan_t chan_from_mask(input logic [31:0] m);
        chan_t c;
        c.sh    = ctz32(m);
        c.level = m >> c.sh;
        return c;
    endfunction

endpackage

// File: hdl/rtvpp_cfg.sv
module rtvpp_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    output rtvpp_pkg::cfg_t     cfg
);

    rtvpp_pkg::cfg_t cfg_reg;

    // Shift and level are derived as each mask is written, so the lanes see them at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red   <= rtvpp_pkg::chan_from_mask(rtvpp_pkg::RED_MASK_RST);
            cfg_reg.green <= rtvpp_pkg::chan_from_mask(rtvpp_pkg::GREEN_MASK_RST);
            cfg_reg.blue  <= rtvpp_pkg::chan_from_mask(rtvpp_pkg::BLUE_MASK_RST);
            cfg_reg.wide  <= 1'b1;
            cfg_reg.msb   <= 1'b0;
            cfg_reg.gray  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rtvpp_pkg::CFG_RED_MASK:   cfg_reg.red   <= rtvpp_pkg::chan_from_mask(cfg_wdata);
                rtvpp_pkg::CFG_GREEN_MASK: cfg_reg.green <= rtvpp_pkg::chan_from_mask(cfg_wdata);
                rtvpp_pkg::CFG_BLUE_MASK:  cfg_reg.blue  <= rtvpp_pkg::chan_from_mask(cfg_wdata);
                rtvpp_pkg::CFG_WIDE:       cfg_reg.wide  <= cfg_wdata[0];
                rtvpp_pkg::CFG_MSB_FIRST:  cfg_reg.msb   <= cfg_wdata[0];
                rtvpp_pkg::CFG_GRAY:       cfg_reg.gray  <= cfg_wdata[0];
                default:                   cfg_reg       <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/rtvpp_lane.sv
module rtvpp_lane (
    input  logic                                clk,
    input  logic [rtvpp_pkg::SAMPLE_BITS-1:0]   sample,
    input  rtvpp_pkg::chan_t                    chan,
    output logic [31:0]                         placed
);

    logic [rtvpp_pkg::PROD_W-1:0] prod_reg;
    logic [31:0]                  q_reg;
    logic [rtvpp_pkg::REM_W-1:0]  plow_reg;
    logic [31:0]                  scaled_reg;
    logic [31:0]                  placed_reg;

    logic [rtvpp_pkg::PROD_W-1:0] q_sum;
    logic [rtvpp_pkg::REM_W-1:0]  rem;
    logic [rtvpp_pkg::CORR_W-1:0] corr;

    // The sum of shifted copies undershoots the quotient by at most NUM_TERMS.
    always_comb
    begin
        q_sum = '0;
        for (int k = 1; k <= rtvpp_pkg::NUM_TERMS; k++) begin
            q_sum = q_sum + (prod_reg >> (k * rtvpp_pkg::SAMPLE_BITS));
        end
    end

    // The remainder is small, so only its low bits need to be formed.
    always_comb
    begin
        rem  = plow_reg
             - rtvpp_pkg::REM_W'({q_reg, {rtvpp_pkg::SAMPLE_BITS{1'b0}}})
             + rtvpp_pkg::REM_W'(q_reg);
        corr = '0;
        for (int j = 1; j <= rtvpp_pkg::NUM_TERMS; j++) begin
            if (rem >= rtvpp_pkg::REM_W'(j * rtvpp_pkg::SAMPLE_MAX))
            begin
                corr = corr + rtvpp_pkg::CORR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= rtvpp_pkg::PROD_W'(sample) * rtvpp_pkg::PROD_W'(chan.level);
        q_reg      <= q_sum[31:0];
        plow_reg   <= prod_reg[rtvpp_pkg::REM_W-1:0];
        scaled_reg <= q_reg + 32'(corr);
        placed_reg <= scaled_reg << chan.sh;
    end

    assign placed = placed_reg;

endmodule

// File: hdl/rtvpp_merge.sv
module rtvpp_merge (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    input  logic [31:0]     placed_red,
    input  logic [31:0]     placed_green,
    input  logic [31:0]     placed_blue,
    input  rtvpp_pkg::cfg_t cfg,
    output logic            done,
    output logic [31:0]     pixel_bytes,
    output logic [2:0]      byte_count
);

    logic        done_reg;
    logic [31:0] bytes_reg;
    logic [2:0]  count_reg;
    logic [31:0] pixel;
    logic [31:0] bytes_next;
    logic [2:0]  count_next;

    always_comb
    begin
        pixel = placed_red | placed_green | placed_blue;
        if (cfg.wide)
        begin
            count_next = rtvpp_pkg::COUNT_WIDE;
            bytes_next = cfg.msb ? {pixel[7:0], pixel[15:8], pixel[23:16], pixel[31:24]}
                                 : pixel;
        end
        else
        begin
            count_next = rtvpp_pkg::COUNT_NARROW;
            bytes_next = cfg.msb ? {16'h0000, pixel[7:0], pixel[15:8]}
                                 : {16'h0000, pixel[15:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        count_reg <= count_next;
    end

    assign done        = done_reg;
    assign pixel_bytes = bytes_reg;
    assign byte_count  = count_reg;

endmodule

// File: hdl/rgb_to_visual_pixel_packer_top.sv
// done marks the pixel taken with start once it has passed the lane stages and the output register.
// Throughput: one pixel per clock; busy never rises, the three channel lanes are fully
// pipelined (multiply, reciprocal estimate, correction, placement) ahead of the output register.
// Reset clears the valid pipeline and done, and loads the default masks and modes.
// The receiver cannot stall: every result is on the ports for exactly one cycle.
module rgb_to_visual_pixel_packer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  sample_red,
    input  logic [7:0]  sample_green,
    input  logic [7:0]  sample_blue,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output logic        done,
    output logic [31:0] pixel_bytes,
    output logic [2:0]  byte_count
);

    rtvpp_pkg::cfg_t cfg;
    logic [3:0]      vld_reg;
    logic [3:0]      vld_next;
    logic            accept;
    logic [rtvpp_pkg::SAMPLE_BITS-1:0] s_red;
    logic [rtvpp_pkg::SAMPLE_BITS-1:0] s_green;
    logic [rtvpp_pkg::SAMPLE_BITS-1:0] s_blue;
    logic [31:0]     placed_red;
    logic [31:0]     placed_green;
    logic [31:0]     placed_blue;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign vld_next = {vld_reg[2:0], accept};

    // Gray mode feeds the red sample to all three lanes.
    assign s_red   = rtvpp_pkg::SAMPLE_BITS'(sample_red);
    assign s_green = cfg.gray ? rtvpp_pkg::SAMPLE_BITS'(sample_red)
                              : rtvpp_pkg::SAMPLE_BITS'(sample_green);
    assign s_blue  = cfg.gray ? rtvpp_pkg::SAMPLE_BITS'(sample_red)
                              : rtvpp_pkg::SAMPLE_BITS'(sample_blue);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    rtvpp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rtvpp_lane u_lane_red (
        .clk    (clk),
        .sample (s_red),
        .chan   (cfg.red),
        .placed (placed_red)
    );

    rtvpp_lane u_lane_green (
        .clk    (clk),
        .sample (s_green),
        .chan   (cfg.green),
        .placed (placed_green)
    );

    rtvpp_lane u_lane_blue (
        .clk    (clk),
        .sample (s_blue),
        .chan   (cfg.blue),
        .placed (placed_blue)
    );

    rtvpp_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_in     (vld_reg[3]),
        .placed_red   (placed_red),
        .placed_green (placed_green),
        .placed_blue  (placed_blue),
        .cfg          (cfg),
        .done         (done),
        .pixel_bytes  (pixel_bytes),
        .byte_count   (byte_count)
    );

endmodule

// File: hdl/rtvpp_checker.sv
`include "rgb_to_visual_pixel_packer_top_defines.svh"

module rtvpp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] pixel_bytes,
    input logic [2:0]  byte_count
);

    logic in_go;

    assign in_go = start && !busy;

    // Every result traces back to an accepted transaction.
    `RTVPP_ASSERT_SAME(a_done_has_source, done, $past(in_go, 5))
    `RTVPP_ASSERT_NEXT(a_go_reaches_stage, in_go, !busy)
    `RTVPP_ASSERT_SAME(a_count_legal, done,
        byte_count == rtvpp_pkg::COUNT_WIDE || byte_count == rtvpp_pkg::COUNT_NARROW)
    // Two-byte pixels leave the upper half of the word clear.
    `RTVPP_ASSERT_SAME(a_narrow_upper_clear, done && byte_count == rtvpp_pkg::COUNT_NARROW,
        pixel_bytes[31:16] == 16'h0000)

endmodule

bind rgb_to_visual_pixel_packer_top rtvpp_checker u_rtvpp_checker (.*);

// File: dv/rgb_to_visual_pixel_packer_top_tb.sv
`timescale 1ns / 100ps

module rgb_to_visual_pixel_packer_top_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PIXELS = 1200;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [31:0] bytes;
        logic [2:0]  count;
    } packed_pixel_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  sample_red;
    logic [7:0]  sample_green;
    logic [7:0]  sample_blue;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        done;
    logic [31:0] pixel_bytes;
    logic [2:0]  byte_count;

    // Shadow copy of the packer's registers.
    logic [31:0] red_place;
    logic [31:0] green_place;
    logic [31:0] blue_place;
    logic        wide_mode;
    logic        msb_mode;
    logic        gray_mode;

    packed_pixel_t pending_pixels[$];
    int mismatches = 0;
    int pixels_sent = 0;
    int narrow_pixels = 0;
    int gray_pixels = 0;
    int msb_pixels = 0;
    int settings_used = 0;
    int drain_pauses = 0;
    int quiet_cycles = 0;

    rgb_to_visual_pixel_packer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_red   (sample_red),
        .sample_green (sample_green),
        .sample_blue  (sample_blue),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .pixel_bytes  (pixel_bytes),
        .byte_count   (byte_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Scale one sample to the channel's level and move it into place.
    function automatic logic [31:0] scale_channel(input logic [7:0] s, input logic [31:0] mask);
        int          sh;
        logic [63:0] level;
        logic [63:0] scaled;
        sh = 0;
        if (mask != 32'd0)
        begin
            while (!mask[sh])
            begin
                sh++;
            end
        end
        level  = 64'(mask >> sh);
        scaled = (64'(s) * level) / 64'(rtvpp_pkg::SAMPLE_MAX);
        return 32'(scaled << sh);
    endfunction

    function automatic packed_pixel_t pack_pixel(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
        logic [31:0]   word;
        packed_pixel_t p;
        if (gray_mode)
        begin
            g = r;
            b = r;
        end
        word = scale_channel(r, red_place) | scale_channel(g, green_place)
             | scale_channel(b, blue_place);
        if (wide_mode)
        begin
            p.count = rtvpp_pkg::COUNT_WIDE;
            p.bytes = msb_mode ? {word[7:0], word[15:8], word[23:16], word[31:24]} : word;
        end
        else
        begin
            p.count = rtvpp_pkg::COUNT_NARROW;
            p.bytes = msb_mode ? {16'h0000, word[7:0], word[15:8]} : {16'h0000, word[15:0]};
        end
        return p;
    endfunction

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_mask();
        int width;
        int lsb;
        case ($urandom_range(0, 6))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            3, 4:
            begin
                width = $urandom_range(1, 8);
                lsb   = $urandom_range(0, 32 - width);
                return 32'(((64'd1 << width) - 1) << lsb);
            end
            default:
            begin
                width = $urandom_range(1, 32);
                lsb   = $urandom_range(0, 32 - width);
                return 32'(((64'd1 << width) - 1) << lsb);
            end
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        @(negedge clk);
        start        = 1'b1;
        sample_red   = r;
        sample_green = g;
        sample_blue  = b;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_pixels.push_back(pack_pixel(r, g, b));
        pixels_sent++;
        if (!wide_mode)
        begin
            narrow_pixels++;
        end
        if (gray_mode)
        begin
            gray_pixels++;
        end
        if (msb_mode)
        begin
            msb_pixels++;
        end
    endtask

    // Drop start for a number of cycles; the sample ports carry noise meanwhile.
    task automatic hold_off(input int cycles);
        @(negedge clk);
        start        = 1'b0;
        sample_red   = 8'($urandom);
        sample_green = 8'($urandom);
        sample_blue  = 8'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        start     = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        case (idx)
            rtvpp_pkg::CFG_RED_MASK:   red_place   = data;
            rtvpp_pkg::CFG_GREEN_MASK: green_place = data;
            rtvpp_pkg::CFG_BLUE_MASK:  blue_place  = data;
            rtvpp_pkg::CFG_WIDE:       wide_mode   = data[0];
            rtvpp_pkg::CFG_MSB_FIRST:  msb_mode    = data[0];
            rtvpp_pkg::CFG_GRAY:       gray_mode   = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_setting(input logic [31:0] r_mask, input logic [31:0] g_mask,
                                 input logic [31:0] b_mask, input logic wide,
                                 input logic msb, input logic gray);
        wait_until_drained();
        write_reg(rtvpp_pkg::CFG_RED_MASK, r_mask);
        write_reg(rtvpp_pkg::CFG_GREEN_MASK, g_mask);
        write_reg(rtvpp_pkg::CFG_BLUE_MASK, b_mask);
        write_reg(rtvpp_pkg::CFG_WIDE, {31'd0, wide});
        write_reg(rtvpp_pkg::CFG_MSB_FIRST, {31'd0, msb});
        write_reg(rtvpp_pkg::CFG_GRAY, {31'd0, gray});
        settings_used++;
    endtask

    // Default 8:8:8 layout straight out of reset, back to back.
    task automatic test_reset_defaults();
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hAA, 8'h55, 8'h80);
        send_pixel(8'h55, 8'hAA, 8'h7F);
        send_pixel(8'h01, 8'hFE, 8'h80);
    endtask

    task automatic test_byte_order();
        for (int mode = 0; mode < 4; mode++)
        begin
            apply_setting(rtvpp_pkg::RED_MASK_RST, rtvpp_pkg::GREEN_MASK_RST,
                          rtvpp_pkg::BLUE_MASK_RST, mode[1], mode[0], 1'b0);
            send_pixel(8'h12, 8'h34, 8'h56);
        end
        // In gray mode green and blue must have no effect.
        apply_setting(rtvpp_pkg::RED_MASK_RST, rtvpp_pkg::GREEN_MASK_RST,
                      rtvpp_pkg::BLUE_MASK_RST, 1'b1, 1'b0, 1'b1);
        send_pixel(8'hC3, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'h12, 8'h00);
    endtask

    task automatic test_special_masks();
        // An empty red mask contributes nothing; green has holes in its mask.
        apply_setting(32'h0000_0000, 32'h0000_0A50, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h80, 8'h80, 8'h80);
        apply_setting(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1, 1'b0);
        send_pixel(8'hFF, 8'h7F, 8'h80);
        send_pixel(8'h7F, 8'hFF, 8'hFF);
        // 5:6:5 in two bytes.
        apply_setting(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 1'b0, 1'b0, 1'b0);
        send_pixel(8'hFF, 8'h80, 8'h3F);
        send_pixel(8'h08, 8'hFF, 8'hFF);
        apply_setting(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
    endtask

    // Random settings, each followed by a bursty stream of random pixels.
    task automatic test_random_stream(input int target);
        int phase_len;
        int burst;
        while (pixels_sent < target)
        begin
            apply_setting(pick_mask(), pick_mask(), pick_mask(),
                          1'($urandom), 1'($urandom), 1'($urandom));
            phase_len = $urandom_range(40, 160);
            while (phase_len > 0)
            begin
                burst = $urandom_range(1, 40);
                repeat (burst)
                begin
                    send_pixel(pick_sample(), pick_sample(), pick_sample());
                end
                phase_len -= burst;
                if ($urandom_range(0, 7) == 0 || drain_pauses == 0)
                begin
                    wait_until_drained();
                    drain_pauses++;
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    hold_off($urandom_range(4, 12));
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    hold_off($urandom_range(1, 3));
                end
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        packed_pixel_t want;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected pixel: bytes=%08h count=%0d", pixel_bytes, byte_count);
                end
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_bytes !== want.bytes || byte_count !== want.count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("pixel mismatch: bytes exp=%08h got=%08h, count exp=%0d got=%0d",
                                 want.bytes, pixel_bytes, want.count, byte_count);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no transaction moves on either side.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we || !rst_n)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        sample_red   = 8'h00;
        sample_green = 8'h00;
        sample_blue  = 8'h00;
        cfg_we       = 1'b0;
        cfg_index    = rtvpp_pkg::CFG_RED_MASK;
        cfg_wdata    = 32'd0;
        red_place    = rtvpp_pkg::RED_MASK_RST;
        green_place  = rtvpp_pkg::GREEN_MASK_RST;
        blue_place   = rtvpp_pkg::BLUE_MASK_RST;
        wide_mode    = 1'b1;
        msb_mode     = 1'b0;
        gray_mode    = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_byte_order();
        test_special_masks();
        test_random_stream(pixels_sent + RANDOM_PIXELS);

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Packed %0d pixels under %0d register settings with %0d full drains.",
                 pixels_sent, settings_used, drain_pauses);
        $display("Of these %0d were 16 bpp, %0d gray, %0d MSB-first; %0d mismatches.",
                 narrow_pixels, gray_pixels, msb_pixels, mismatches);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/rtvpp_pkg.sv
hdl/rtvpp_cfg.sv
hdl/rtvpp_lane.sv
hdl/rtvpp_merge.sv
hdl/rgb_to_visual_pixel_packer_top.sv
hdl/rtvpp_checker.sv
dv/rgb_to_visual_pixel_packer_top_tb.sv
